// ===== rtl/vtxang_pkg.sv =====
// ----------------------------------------------------------------------------
// vtxang_pkg
// Shared constants, types and the arctangent table for the vertex angle block.
// ----------------------------------------------------------------------------
package vtxang_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 20;

  localparam int IN_FIELDS   = 6;
  localparam int IN_DATA_W   = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((ANGLE_WIDTH + 7) / 8) * 8;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  // three spare bits cover the CORDIC gain and the sqrt(2) of the corner case
  localparam int WORK_W  = DIFF_W + GUARD_BITS + 3;
  localparam int TURN_W  = 32;
  localparam int SHIFT_W = 5;

  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [TURN_W-1:0] ROUND_ADD =
    (ANGLE_WIDTH < TURN_W) ? (TURN_W'(1) << (TURN_W - 1 - ANGLE_WIDTH)) : '0;

  typedef struct packed {
    logic                     zero;
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] y;
    logic [TURN_W-1:0]        z;
  } vec_t;

  typedef struct packed {
    vec_t a;
    vec_t b;
  } pair_t;

  // round(atan(2^-i) / (2 pi) * 2^32)
  function automatic logic [TURN_W-1:0] atan_turns(input logic [SHIFT_W-1:0] idx);
    logic [TURN_W-1:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      5'd24:   r = 32'h00000029;
      5'd25:   r = 32'h00000014;
      5'd26:   r = 32'h0000000A;
      5'd27:   r = 32'h00000005;
      5'd28:   r = 32'h00000003;
      5'd29:   r = 32'h00000001;
      5'd30:   r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/vtxang_front.sv =====
// ----------------------------------------------------------------------------
// vtxang_front
// Forms both arm vectors from the vertex, scales them and folds them into the
// right half plane, giving the start state of the CORDIC chain.
// ----------------------------------------------------------------------------
module vtxang_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [vtxang_pkg::IN_DATA_W-1:0] data_i,
  output logic                            valid_o,
  output vtxang_pkg::pair_t               data_o
);

  localparam int CW = vtxang_pkg::COORD_WIDTH;
  localparam int DW = vtxang_pkg::DIFF_W;
  localparam int WW = vtxang_pkg::WORK_W;
  localparam int GB = vtxang_pkg::GUARD_BITS;

  logic [CW-1:0] fx, fy, vx, vy, tx, ty;
  vtxang_pkg::pair_t data_d, data_q;
  logic              valid_q;

  assign fx = data_i[0*CW +: CW];
  assign fy = data_i[1*CW +: CW];
  assign vx = data_i[2*CW +: CW];
  assign vy = data_i[3*CW +: CW];
  assign tx = data_i[4*CW +: CW];
  assign ty = data_i[5*CW +: CW];

  function automatic vtxang_pkg::vec_t start_vec(input logic [CW-1:0] px,
                                                 input logic [CW-1:0] py,
                                                 input logic [CW-1:0] cx,
                                                 input logic [CW-1:0] cy);
    logic [DW-1:0]          dx, dy;
    logic signed [WW-1:0]   sx, sy;
    vtxang_pkg::vec_t       v;
    dx = {px[CW-1], px} - {cx[CW-1], cx};
    dy = {py[CW-1], py} - {cy[CW-1], cy};
    sx = {{(WW-DW-GB){dx[DW-1]}}, dx, {GB{1'b0}}};
    sy = {{(WW-DW-GB){dy[DW-1]}}, dy, {GB{1'b0}}};
    v.zero = (dx == '0) && (dy == '0);
    if (dx[DW-1]) begin
      v.x = -sx;
      v.y = -sy;
      v.z = vtxang_pkg::HALF_TURN;
    end else begin
      v.x = sx;
      v.y = sy;
      v.z = '0;
    end
    return v;
  endfunction

  always_comb begin
    data_d.a = start_vec(fx, fy, vx, vy);
    data_d.b = start_vec(tx, ty, vx, vy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/vtxang_cell.sv =====
// ----------------------------------------------------------------------------
// vtxang_cell
// One vectoring CORDIC micro-rotation for both arm vectors, registered.
// ----------------------------------------------------------------------------
module vtxang_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [vtxang_pkg::SHIFT_W-1:0]    shift_i,
  input  logic                              valid_i,
  input  vtxang_pkg::pair_t                 data_i,
  output logic                              valid_o,
  output vtxang_pkg::pair_t                 data_o
);

  localparam int WW = vtxang_pkg::WORK_W;

  logic [vtxang_pkg::TURN_W-1:0] step_angle;
  vtxang_pkg::pair_t             data_d, data_q;
  logic                          valid_q;

  assign step_angle = vtxang_pkg::atan_turns(shift_i);

  function automatic vtxang_pkg::vec_t rotate(input vtxang_pkg::vec_t v,
                                              input logic [vtxang_pkg::SHIFT_W-1:0] sh,
                                              input logic [vtxang_pkg::TURN_W-1:0] ang);
    logic signed [WW-1:0] sx, sy;
    vtxang_pkg::vec_t     r;
    sx = v.x >>> sh;
    sy = v.y >>> sh;
    r.zero = v.zero;
    // rotate toward the x axis: clockwise while y is not negative
    if (!v.y[WW-1]) begin
      r.x = v.x + sy;
      r.y = v.y - sx;
      r.z = v.z + ang;
    end else begin
      r.x = v.x - sy;
      r.y = v.y + sx;
      r.z = v.z - ang;
    end
    return r;
  endfunction

  always_comb begin
    data_d.a = rotate(data_i.a, shift_i, step_angle);
    data_d.b = rotate(data_i.b, shift_i, step_angle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  a_zero_vec_stays_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((!data_o.a.zero || (data_o.a.x == '0 && data_o.a.y == '0)) &&
                 (!data_o.b.zero || (data_o.b.x == '0 && data_o.b.y == '0))))
    else $error("zero vector picked up a nonzero component");

  a_x_not_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!data_o.a.x[WW-1] && !data_o.b.x[WW-1]))
    else $error("x left the right half plane");

  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o))
    else $error("cell valid moved during stall");

  a_stall_holds_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en_i && valid_o) |=> $stable(data_o))
    else $error("cell data moved during stall");
`endif

endmodule

// ===== rtl/vertex_angle_three_points.sv =====
// ----------------------------------------------------------------------------
// vertex_angle_three_points
// Angle at a vertex from the second arm to the first arm, as a fraction of a
// full turn, by a chain of CORDIC cells running both arms side by side.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  s_axis    in   first_x, first_y, vertex_x, vertex_y, third_x, third_y
//  m_axis    out  angle_turns
//
//  Takes one beat per cycle while m_axis_tready does not hold the output;
//  each beat passes the front register, one register per cell, then the output register.
//  The whole chain advances together: it freezes while the output beat
//  waits, so s_axis_tready follows the output register's free state.
//  Reset clears only the valid bits of the chain and the output register.
// ----------------------------------------------------------------------------
module vertex_angle_three_points (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_x, first_y, vertex_x, vertex_y, third_x, third_y
  input  logic [vtxang_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // angle_turns
  output logic [vtxang_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int STEPS = vtxang_pkg::CORDIC_STEPS;
  localparam int AW    = vtxang_pkg::ANGLE_WIDTH;
  localparam int TW    = vtxang_pkg::TURN_W;

  logic              en;
  logic              chain_valid [0:STEPS];
  vtxang_pkg::pair_t chain_data  [0:STEPS];

  logic [TW-1:0] ang_a, ang_b, ang_diff, ang_rnd;
  logic [AW-1:0] angle_d, angle_q;
  logic          out_valid_q;

  // advance when the output register is free or being drained
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  vtxang_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    vtxang_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (vtxang_pkg::SHIFT_W'(g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // a zero vector has angle zero
  assign ang_a    = chain_data[STEPS].a.zero ? '0 : chain_data[STEPS].a.z;
  assign ang_b    = chain_data[STEPS].b.zero ? '0 : chain_data[STEPS].b.z;
  assign ang_diff = ang_a - ang_b;
  assign ang_rnd  = ang_diff + vtxang_pkg::ROUND_ADD;
  assign angle_d  = ang_rnd[TW-1 -: AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = vtxang_pkg::OUT_DATA_W'(angle_q);

endmodule
